// ===== src/rpn_stack_evaluator_defines.svh =====
`ifndef RPN_STACK_EVALUATOR_DEFINES_SVH
`define RPN_STACK_EVALUATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define RPN_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define RPN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rpn_pkg.sv =====
`timescale 1ns / 1ps

package rpn_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned DIV_STEPS   = DATA_W;
  localparam int unsigned STEP_W      = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    KIND_DIGIT   = 2'd0,
    KIND_OP      = 2'd1,
    KIND_INVALID = 2'd2,
    KIND_END     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_DIVZERO   = 3'd2,
    ST_INVALID   = 3'd3,
    ST_IMBALANCE = 3'd4,
    ST_OVERFLOW  = 3'd5
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic    tok_load;
    logic    rd_next;
    logic    right_load;
    logic    push_digit;
    logic    push_alu;
    logic    push_div;
    logic    drop2;
    logic    div_start;
    logic    emit;
    logic    err_load;
    status_t err_code;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    kind_t kind;
    op_t   op;
    logic  err_pending;
    logic  full;
    logic  lt2;
    logic  right_zero;
    logic  div_done;
  } sts_t;

endpackage

// ===== src/rpn_div.sv =====
`timescale 1ns / 1ps

module rpn_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [rpn_pkg::DATA_W-1:0]        dividend,
  input  logic [rpn_pkg::DATA_W-1:0]        divisor,
  output logic                              done,
  output logic [rpn_pkg::DATA_W-1:0]        quotient
);

  logic                          run_r;
  logic                          done_r;
  logic [rpn_pkg::STEP_W-1:0]    step_r;
  logic [rpn_pkg::DATA_W-1:0]    rem_r;
  logic [rpn_pkg::DATA_W-1:0]    quo_r;
  logic [rpn_pkg::DATA_W-1:0]    dvs_r;
  logic                          neg_r;

  logic [rpn_pkg::DATA_W-1:0]    mag_a;
  logic [rpn_pkg::DATA_W-1:0]    mag_b;
  logic [rpn_pkg::DATA_W:0]      shifted;
  logic [rpn_pkg::DATA_W:0]      trial;

  always_comb begin
    mag_a   = dividend[rpn_pkg::DATA_W-1] ? ('0 - dividend) : dividend;
    mag_b   = divisor[rpn_pkg::DATA_W-1] ? ('0 - divisor) : divisor;
    // partial remainder stays below twice the divisor, so the top bit is the borrow
    shifted = {rem_r, quo_r[rpn_pkg::DATA_W-1]};
    trial   = shifted - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + rpn_pkg::STEP_W'(1);
        if (step_r == rpn_pkg::STEP_W'(rpn_pkg::DIV_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= mag_a;
      dvs_r <= mag_b;
      neg_r <= dividend[rpn_pkg::DATA_W-1] ^ divisor[rpn_pkg::DATA_W-1];
    end else if (run_r) begin
      if (!trial[rpn_pkg::DATA_W]) begin
        rem_r <= trial[rpn_pkg::DATA_W-1:0];
        quo_r <= {quo_r[rpn_pkg::DATA_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[rpn_pkg::DATA_W-1:0];
        quo_r <= {quo_r[rpn_pkg::DATA_W-2:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? ('0 - quo_r) : quo_r;

endmodule

// ===== src/rpn_dp.sv =====
`timescale 1ns / 1ps
`include "rpn_stack_evaluator_defines.svh"

module rpn_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [1:0]                  in_kind,
  input  logic [3:0]                  in_digit_value,
  input  logic [1:0]                  in_op_code,
  input  rpn_pkg::cmd_t               cmd,
  output rpn_pkg::sts_t               sts,
  output logic                        out_valid,
  output logic signed [31:0]          out_value,
  output logic [2:0]                  out_status
);

  logic [rpn_pkg::DATA_W-1:0]  mem [rpn_pkg::STACK_DEPTH];

  rpn_pkg::kind_t              kind_r;
  rpn_pkg::op_t                op_r;
  logic [3:0]                  digit_r;
  logic [rpn_pkg::CNT_W-1:0]   cnt_r;
  logic [rpn_pkg::CNT_W-1:0]   cnt_nxt;
  rpn_pkg::status_t            err_r;
  rpn_pkg::status_t            err_nxt;
  logic [rpn_pkg::DATA_W-1:0]  rd_data_r;
  logic [rpn_pkg::DATA_W-1:0]  right_r;
  logic                        out_valid_r;
  logic [rpn_pkg::DATA_W-1:0]  out_value_r;
  rpn_pkg::status_t            out_status_r;

  logic [rpn_pkg::CNT_W-1:0]   cnt_m1;
  logic [rpn_pkg::CNT_W-1:0]   cnt_m2;
  logic [rpn_pkg::ADDR_W-1:0]  rd_addr;
  logic                        wr_en;
  logic [rpn_pkg::ADDR_W-1:0]  wr_addr;
  logic [rpn_pkg::DATA_W-1:0]  wr_data;
  logic [rpn_pkg::DATA_W-1:0]  alu_res;
  logic [rpn_pkg::DATA_W-1:0]  div_q;
  logic                        div_done;
  rpn_pkg::status_t            res_status;
  logic [rpn_pkg::DATA_W-1:0]  res_value;

  rpn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (rd_data_r),
    .divisor  (right_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    cnt_m1  = cnt_r - rpn_pkg::CNT_W'(1);
    cnt_m2  = cnt_r - rpn_pkg::CNT_W'(2);
    rd_addr = cmd.rd_next ? cnt_m2[rpn_pkg::ADDR_W-1:0] : cnt_m1[rpn_pkg::ADDR_W-1:0];

    // left operand sits in rd_data_r, right operand in right_r
    case (op_r)
      rpn_pkg::OP_ADD: alu_res = rd_data_r + right_r;
      rpn_pkg::OP_SUB: alu_res = rd_data_r - right_r;
      rpn_pkg::OP_MUL: alu_res = rd_data_r * right_r;
      default:         alu_res = '0;
    endcase

    wr_en   = cmd.push_digit | cmd.push_alu | cmd.push_div;
    wr_addr = cnt_m2[rpn_pkg::ADDR_W-1:0];
    wr_data = div_q;
    if (cmd.push_digit) begin
      wr_addr = cnt_r[rpn_pkg::ADDR_W-1:0];
      wr_data = {{(rpn_pkg::DATA_W - 4){1'b0}}, digit_r};
    end else if (cmd.push_alu) begin
      wr_data = alu_res;
    end

    cnt_nxt = cnt_r;
    if (cmd.emit) begin
      cnt_nxt = '0;
    end else if (cmd.push_digit) begin
      cnt_nxt = cnt_r + rpn_pkg::CNT_W'(1);
    end else if (cmd.push_alu || cmd.push_div) begin
      cnt_nxt = cnt_m1;
    end else if (cmd.drop2) begin
      cnt_nxt = cnt_m2;
    end

    err_nxt = err_r;
    if (cmd.emit) begin
      err_nxt = rpn_pkg::ST_OK;
    end else if (cmd.err_load) begin
      err_nxt = cmd.err_code;
    end

    if (err_r != rpn_pkg::ST_OK) begin
      res_status = err_r;
    end else if (cnt_r == rpn_pkg::CNT_W'(1)) begin
      res_status = rpn_pkg::ST_OK;
    end else begin
      res_status = rpn_pkg::ST_IMBALANCE;
    end
    // with one value on the stack the top read is entry zero
    res_value = (res_status == rpn_pkg::ST_OK) ? rd_data_r : '0;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.tok_load) begin
      kind_r  <= rpn_pkg::kind_t'(in_kind);
      op_r    <= rpn_pkg::op_t'(in_op_code);
      digit_r <= in_digit_value;
    end
    if (cmd.right_load) begin
      right_r <= rd_data_r;
    end
    if (cmd.emit) begin
      out_value_r  <= res_value;
      out_status_r <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      err_r       <= rpn_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  always_comb begin
    sts.kind        = kind_r;
    sts.op          = op_r;
    sts.err_pending = (err_r != rpn_pkg::ST_OK);
    sts.full        = (cnt_r == rpn_pkg::CNT_W'(rpn_pkg::STACK_DEPTH));
    sts.lt2         = (cnt_r < rpn_pkg::CNT_W'(2));
    sts.right_zero  = (right_r == '0);
    sts.div_done    = div_done;
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  `RPN_ASSERT_SAME(a_cnt_bound, 1'b1,
                   cnt_r <= rpn_pkg::CNT_W'(rpn_pkg::STACK_DEPTH),
                   "stack count past depth")
  `RPN_ASSERT_SAME(a_err_zero_value,
                   out_valid_r && out_status_r != rpn_pkg::ST_OK,
                   out_value_r == '0,
                   "error result with nonzero value")
  `RPN_ASSERT_NEXT(a_emit_clears, cmd.emit,
                   cnt_r == '0 && err_r == rpn_pkg::ST_OK,
                   "expression state not cleared after result")

endmodule

// ===== src/rpn_ctrl.sv =====
`timescale 1ns / 1ps
`include "rpn_stack_evaluator_defines.svh"

module rpn_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  rpn_pkg::sts_t sts,
  output rpn_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_DISPATCH = 4'b0010,
    S_EXEC     = 4'b0100,
    S_DIV      = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.tok_load = 1'b1;
          state_nxt    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_IDLE;
        if (sts.kind == rpn_pkg::KIND_END) begin
          cmd.emit = 1'b1;
        end else if (!sts.err_pending) begin
          case (sts.kind)
            rpn_pkg::KIND_DIGIT: begin
              if (sts.full) begin
                cmd.err_load = 1'b1;
                cmd.err_code = rpn_pkg::ST_OVERFLOW;
              end else begin
                cmd.push_digit = 1'b1;
              end
            end
            rpn_pkg::KIND_OP: begin
              if (sts.lt2) begin
                cmd.err_load = 1'b1;
                cmd.err_code = rpn_pkg::ST_UNDERFLOW;
              end else begin
                // top of stack becomes the right operand, fetch the left one
                cmd.right_load = 1'b1;
                cmd.rd_next    = 1'b1;
                state_nxt      = S_EXEC;
              end
            end
            default: begin
              cmd.err_load = 1'b1;
              cmd.err_code = rpn_pkg::ST_INVALID;
            end
          endcase
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        if (sts.op == rpn_pkg::OP_DIV) begin
          if (sts.right_zero) begin
            cmd.drop2    = 1'b1;
            cmd.err_load = 1'b1;
            cmd.err_code = rpn_pkg::ST_DIVZERO;
          end else begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end
        end else begin
          cmd.push_alu = 1'b1;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.push_div = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  `RPN_ASSERT_NEXT(a_accept_dispatch, start && !busy, state_r == S_DISPATCH,
                   "accepted token not dispatched")
  `RPN_ASSERT_SAME(a_div_nonzero, cmd.div_start, !sts.right_zero,
                   "divider started with zero divisor")

endmodule

// ===== src/rpn_stack_evaluator.sv =====
`timescale 1ns / 1ps

// Reverse Polish evaluator, one token per transfer on start/busy. A token is
// taken when start is high and busy is low. Digit, invalid and end tokens, an
// operator short of operands and any token ignored after an error go through
// dispatch only; add, subtract, multiply and a divide by zero also go through
// execute; a divide then waits in S_DIV on the radix-2 divider that finds one
// quotient bit a cycle over 32 steps. Only the end token gives a transfer on
// the out_ ports: out_valid is high for one cycle, the cycle after the end
// token is dispatched, and the receiver cannot stall it, so it must take every
// result as it comes. The next token may be started in that same cycle.
module rpn_stack_evaluator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_kind,
  input  logic [3:0]         in_digit_value,
  input  logic [1:0]         in_op_code,
  output logic               out_valid,
  output logic signed [31:0] out_value,
  output logic [2:0]         out_status
);

  rpn_pkg::cmd_t cmd;
  rpn_pkg::sts_t sts;

  rpn_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  rpn_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_kind        (in_kind),
    .in_digit_value (in_digit_value),
    .in_op_code     (in_op_code),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_value      (out_value),
    .out_status     (out_status)
  );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES    = 60;
  localparam int unsigned PHASE_TOKENS   = 225;

  typedef struct {
    rpn_pkg::kind_t kind;
    logic [3:0]     digit;
    rpn_pkg::op_t   op;
    bit             drain;
  } token_t;

  typedef struct {
    logic signed [31:0] value;
    rpn_pkg::status_t   status;
  } outcome_t;

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               start          = 1'b0;
  logic [1:0]         in_kind        = '0;
  logic [3:0]         in_digit_value = '0;
  logic [1:0]         in_op_code     = '0;
  logic               busy;
  logic               out_valid;
  logic signed [31:0] out_value;
  logic [2:0]         out_status;

  token_t      pending_tokens[$];
  outcome_t    expected_results[$];
  int unsigned send_idle_pct = 22;
  int          ends_open     = 0;
  int unsigned mismatches    = 0;
  int unsigned quiet_cycles  = 0;

  // shadow of the evaluator
  logic [31:0]      operand_stk[rpn_pkg::STACK_DEPTH];
  int unsigned      stk_count = 0;
  rpn_pkg::status_t first_err = rpn_pkg::ST_OK;

  rpn_stack_evaluator u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_digit_value (in_digit_value),
    .in_op_code     (in_op_code),
    .out_valid      (out_valid),
    .out_value      (out_value),
    .out_status     (out_status)
  );

  always #6 clk = ~clk;

  function automatic logic [31:0] div_trunc(logic [31:0] num, logic [31:0] den);
    logic [31:0] num_mag, den_mag, quo;
    num_mag = num[31] ? 32'd0 - num : num;
    den_mag = den[31] ? 32'd0 - den : den;
    quo = num_mag / den_mag;
    return (num[31] ^ den[31]) ? 32'd0 - quo : quo;
  endfunction

  function automatic void eval_token(rpn_pkg::kind_t kind, logic [3:0] digit,
                                     rpn_pkg::op_t op);
    logic [31:0] lhs, rhs, res;
    outcome_t    out;
    if (kind == rpn_pkg::KIND_END) begin
      out.value  = '0;
      out.status = first_err;
      if (first_err == rpn_pkg::ST_OK) begin
        if (stk_count == 1) out.value = operand_stk[0];
        else out.status = rpn_pkg::ST_IMBALANCE;
      end
      expected_results.push_back(out);
      stk_count = 0;
      first_err = rpn_pkg::ST_OK;
    end else if (first_err == rpn_pkg::ST_OK) begin
      case (kind)
        rpn_pkg::KIND_DIGIT: begin
          if (stk_count >= rpn_pkg::STACK_DEPTH) begin
            first_err = rpn_pkg::ST_OVERFLOW;
          end else begin
            operand_stk[stk_count] = {28'd0, digit};
            stk_count++;
          end
        end
        rpn_pkg::KIND_OP: begin
          if (stk_count < 2) begin
            first_err = rpn_pkg::ST_UNDERFLOW;
          end else begin
            rhs = operand_stk[stk_count - 1];
            lhs = operand_stk[stk_count - 2];
            stk_count -= 2;
            if (op == rpn_pkg::OP_DIV && rhs == 32'd0) begin
              // operands stay popped
              first_err = rpn_pkg::ST_DIVZERO;
            end else begin
              case (op)
                rpn_pkg::OP_ADD: res = lhs + rhs;
                rpn_pkg::OP_SUB: res = lhs - rhs;
                rpn_pkg::OP_MUL: res = lhs * rhs;
                default:         res = div_trunc(lhs, rhs);
              endcase
              operand_stk[stk_count] = res;
              stk_count++;
            end
          end
        end
        default: first_err = rpn_pkg::ST_INVALID;
      endcase
    end
  endfunction

  function automatic rpn_pkg::op_t any_op();
    return rpn_pkg::op_t'($urandom_range(3));
  endfunction

  function automatic void add_tok(rpn_pkg::kind_t kind, int unsigned digit, rpn_pkg::op_t op);
    token_t tok;
    tok.kind  = kind;
    tok.digit = 4'(digit);
    tok.op    = op;
    tok.drain = 1'b0;
    pending_tokens.push_back(tok);
  endfunction

  // well-formed expression over n digits, push_pct biases toward deep stacks
  function automatic void add_expression(int unsigned n, int unsigned push_pct);
    int unsigned left_to_push, stacked;
    left_to_push = n;
    stacked = 0;
    while (left_to_push != 0 || stacked > 1) begin
      if (left_to_push != 0 && (stacked < 2 || $urandom_range(99) < push_pct)) begin
        add_tok(rpn_pkg::KIND_DIGIT, $urandom_range(15), any_op());
        left_to_push--;
        stacked++;
      end else begin
        add_tok(rpn_pkg::KIND_OP, $urandom_range(15), any_op());
        stacked--;
      end
    end
    add_tok(rpn_pkg::KIND_END, $urandom_range(15), any_op());
  endfunction

  function automatic void fill_phase(int unsigned count);
    int unsigned goal, pick, mark, spot, n, push_pct;
    goal = pending_tokens.size() + count;
    while (pending_tokens.size() < goal) begin
      mark = pending_tokens.size();
      pick = $urandom_range(99);
      n = $urandom_range(99) < 70 ? $urandom_range(1, 4) :
          $urandom_range(99) < 85 ? $urandom_range(5, 10) : $urandom_range(11, 16);
      case ($urandom_range(2))
        0:       push_pct = 35;
        1:       push_pct = 60;
        default: push_pct = 95;
      endcase
      if (pick < 60) begin
        add_expression(n, push_pct);
      end else if (pick < 75) begin
        // one token dropped or turned into something else
        add_expression(n, push_pct);
        spot = $urandom_range(mark, pending_tokens.size() - 2);
        if ($urandom_range(1)) begin
          pending_tokens.delete(spot);
        end else begin
          pending_tokens[spot].kind  = rpn_pkg::kind_t'($urandom_range(2));
          pending_tokens[spot].digit = 4'($urandom_range(15));
          pending_tokens[spot].op    = any_op();
        end
      end else if (pick < 83) begin
        // fill the stack past its top, then tokens that must be ignored
        repeat (rpn_pkg::STACK_DEPTH + 1 + $urandom_range(1))
          add_tok(rpn_pkg::KIND_DIGIT, $urandom_range(15), any_op());
        repeat ($urandom_range(3))
          add_tok(rpn_pkg::kind_t'($urandom_range(2)), $urandom_range(15), any_op());
        add_tok(rpn_pkg::KIND_END, $urandom_range(15), any_op());
      end else if (pick < 88) begin
        // 2 * 8^10 wraps to the most negative value
        add_tok(rpn_pkg::KIND_DIGIT, 2, any_op());
        repeat (10) begin
          add_tok(rpn_pkg::KIND_DIGIT, 8, any_op());
          add_tok(rpn_pkg::KIND_OP, $urandom_range(15), rpn_pkg::OP_MUL);
        end
        if ($urandom_range(1)) begin
          add_tok(rpn_pkg::KIND_DIGIT, 0, any_op());
          add_tok(rpn_pkg::KIND_DIGIT, 1, any_op());
          add_tok(rpn_pkg::KIND_OP, $urandom_range(15), rpn_pkg::OP_SUB);
        end else begin
          add_tok(rpn_pkg::KIND_DIGIT, $urandom_range(15), any_op());
        end
        add_tok(rpn_pkg::KIND_OP, $urandom_range(15), rpn_pkg::OP_DIV);
        add_tok(rpn_pkg::KIND_END, $urandom_range(15), any_op());
      end else begin
        repeat ($urandom_range(1, 6))
          add_tok(rpn_pkg::kind_t'($urandom_range(3)), $urandom_range(15), any_op());
      end
      if ($urandom_range(99) < 4) pending_tokens[mark].drain = 1'b1;
    end
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_tokens.size() != 0 || start || busy !== 1'b0 ||
           expected_results.size() != 0);
  endtask

  // token driver
  always @(posedge clk) begin
    token_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
      ends_open = 0;
    end else begin
      if (start && !busy && in_kind == rpn_pkg::KIND_END) ends_open++;
      if (out_valid) ends_open--;
      if (!start || !busy) begin
        if (pending_tokens.size() == 0 || $urandom_range(99) < send_idle_pct ||
            (pending_tokens[0].drain && ends_open != 0)) begin
          start <= 1'b0;
        end else begin
          nxt = pending_tokens.pop_front();
          start          <= 1'b1;
          in_kind        <= nxt.kind;
          in_digit_value <= nxt.digit;
          in_op_code     <= nxt.op;
        end
      end
    end
  end

  // result monitor and shadow update
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: value %0d status %0d", out_value, out_status);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_value !== want.value || out_status !== want.status) begin
            if (mismatches < 10)
              $display({"result mismatch: expected value %0d status %0d, ",
                        "got value %0d status %0d"},
                       want.value, want.status, out_value, out_status);
            mismatches++;
          end
        end
      end
      if (start && !busy)
        eval_token(rpn_pkg::kind_t'(in_kind), in_digit_value, rpn_pkg::op_t'(in_op_code));
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // 9 + 3
    add_tok(rpn_pkg::KIND_DIGIT, 9, rpn_pkg::OP_ADD);
    add_tok(rpn_pkg::KIND_DIGIT, 3, rpn_pkg::OP_MUL);
    add_tok(rpn_pkg::KIND_OP, 0, rpn_pkg::OP_ADD);
    add_tok(rpn_pkg::KIND_END, 15, rpn_pkg::OP_DIV);
    // 0 - 15 with a digit above nine, held until the first result is out
    add_tok(rpn_pkg::KIND_DIGIT, 0, rpn_pkg::OP_SUB);
    pending_tokens[4].drain = 1'b1;
    add_tok(rpn_pkg::KIND_DIGIT, 15, rpn_pkg::OP_DIV);
    add_tok(rpn_pkg::KIND_OP, 15, rpn_pkg::OP_SUB);
    add_tok(rpn_pkg::KIND_END, 0, rpn_pkg::OP_ADD);
    // 7 * 6
    add_tok(rpn_pkg::KIND_DIGIT, 7, rpn_pkg::OP_DIV);
    add_tok(rpn_pkg::KIND_DIGIT, 6, rpn_pkg::OP_ADD);
    add_tok(rpn_pkg::KIND_OP, 5, rpn_pkg::OP_MUL);
    add_tok(rpn_pkg::KIND_END, 10, rpn_pkg::OP_SUB);
    // 15 / 4
    add_tok(rpn_pkg::KIND_DIGIT, 15, rpn_pkg::OP_ADD);
    add_tok(rpn_pkg::KIND_DIGIT, 4, rpn_pkg::OP_ADD);
    add_tok(rpn_pkg::KIND_OP, 0, rpn_pkg::OP_DIV);
    add_tok(rpn_pkg::KIND_END, 0, rpn_pkg::OP_ADD);
    // operator on an empty stack
    add_tok(rpn_pkg::KIND_OP, 3, rpn_pkg::OP_DIV);
    add_tok(rpn_pkg::KIND_END, 0, rpn_pkg::OP_ADD);
    // divide by zero
    add_tok(rpn_pkg::KIND_DIGIT, 5, rpn_pkg::OP_ADD);
    add_tok(rpn_pkg::KIND_DIGIT, 0, rpn_pkg::OP_ADD);
    add_tok(rpn_pkg::KIND_OP, 0, rpn_pkg::OP_DIV);
    add_tok(rpn_pkg::KIND_END, 0, rpn_pkg::OP_ADD);
    // invalid token, the digit after it is ignored
    add_tok(rpn_pkg::KIND_INVALID, 12, rpn_pkg::OP_MUL);
    add_tok(rpn_pkg::KIND_DIGIT, 4, rpn_pkg::OP_ADD);
    add_tok(rpn_pkg::KIND_END, 0, rpn_pkg::OP_ADD);
    // end with nothing stacked, then with two values
    add_tok(rpn_pkg::KIND_END, 0, rpn_pkg::OP_ADD);
    add_tok(rpn_pkg::KIND_DIGIT, 1, rpn_pkg::OP_ADD);
    add_tok(rpn_pkg::KIND_DIGIT, 2, rpn_pkg::OP_ADD);
    add_tok(rpn_pkg::KIND_END, 0, rpn_pkg::OP_ADD);
    fill_phase(PHASE_TOKENS);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait_idle();

    send_idle_pct = 64;
    fill_phase(PHASE_TOKENS);
    wait_idle();

    send_idle_pct = 0;
    fill_phase(PHASE_TOKENS);
    wait_idle();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
